FILE: design/hcr_pkg.sv
package hcr_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam logic [10:0] WIDTH_RST  = 11'd640;
    localparam logic [11:0] HEIGHT_RST = 12'd480;
    localparam logic [15:0] ALPHA_RST  = 16'd2621;
    localparam logic [15:0] WSIDE_RST  = 16'd20172;
    localparam logic [15:0] WCTR_RST   = 16'd25193;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_ALPHA  = 3'd2;
    localparam logic [2:0] REG_WSIDE  = 3'd3;
    localparam logic [2:0] REG_WCTR   = 3'd4;

    localparam logic signed [43:0] RESP_MAX = {1'b0, {43{1'b1}}};
    localparam logic signed [43:0] RESP_MIN = {1'b1, {43{1'b0}}};

    // controller -> datapath commands
    typedef struct packed {
        logic load;     // capture input, read line buffers
        logic mirror;   // row 1: row above is the current row
        logic pass2;    // second result: mirrored last row
        logic step;     // advance one arithmetic stage
        logic wr;       // write current products to the line buffer
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic done;     // response register holds a finished result
    } t_sts;

endpackage

FILE: design/hcr_datapath.sv
module hcr_datapath #(
    parameter int MAX_WIDTH = hcr_pkg::MAX_WIDTH_DEF,
    parameter int AW = $clog2(MAX_WIDTH)
) (
    input  logic                i_clk,
    input  hcr_pkg::t_cmd       i_cmd,
    input  logic [3:0]          i_stage,
    input  logic [AW:0]         i_addr,
    input  logic signed [10:0]  i_grad_x,
    input  logic signed [10:0]  i_grad_y,
    input  logic [15:0]         i_alpha,
    input  logic [15:0]         i_wside,
    input  logic [15:0]         i_wctr,
    output logic signed [43:0]  o_resp
);
    localparam logic signed [65:0] RESP_MAX_C = 66'(hcr_pkg::RESP_MAX);
    localparam logic signed [65:0] RESP_MIN_C = 66'(hcr_pkg::RESP_MIN);

    // two row halves, row parity in the top address bit
    logic [20:0] r_mem_xx [2**(AW+1)];
    logic [20:0] r_mem_yy [2**(AW+1)];
    logic signed [21:0] r_mem_xy [2**(AW+1)];

    logic signed [10:0] r_gx, r_gy;
    logic [20:0] r_cxx, r_cyy, r_oxx, r_oyy, r_pxx, r_pyy;
    logic signed [21:0] r_cxy, r_oxy, r_pxy;
    logic [38:0] r_fxx, r_fyy;   // smoothed sums before rounding
    logic signed [40:0] r_fxy;
    logic [22:0] r_gxx, r_gyy;
    logic signed [23:0] r_gxy;
    logic signed [47:0] r_det;
    logic [47:0] r_tt;
    logic [63:0] r_at;
    logic signed [43:0] r_resp;

    logic [AW:0] r_waddr;

    // per-stage shared terms
    logic [21:0] a_xx, a_yy;
    logic signed [22:0] a_xy;
    logic [20:0] c_xx, c_yy;
    logic signed [21:0] c_xy;
    logic [23:0] t_sum;
    logic signed [65:0] r_full;

    always_comb begin
        c_xx = r_pxx; c_yy = r_pyy; c_xy = r_pxy;
        a_xx = {1'b0, r_oxx} + {1'b0, r_cxx};
        a_yy = {1'b0, r_oyy} + {1'b0, r_cyy};
        a_xy = 23'(r_oxy) + 23'(r_cxy);
        if (i_cmd.pass2) begin
            c_xx = r_cxx; c_yy = r_cyy; c_xy = r_cxy;
            a_xx = {r_pxx, 1'b0};
            a_yy = {r_pyy, 1'b0};
            a_xy = {r_pxy, 1'b0};
        end
        t_sum  = {1'b0, r_gxx} + {1'b0, r_gyy};
        r_full = 66'(r_det) - $signed({2'b0, r_at});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_gx <= i_grad_x;
            r_gy <= i_grad_y;
            r_waddr <= i_addr;
            r_oxx <= r_mem_xx[i_addr];
            r_oyy <= r_mem_yy[i_addr];
            r_oxy <= r_mem_xy[i_addr];
            r_pxx <= r_mem_xx[{~i_addr[AW], i_addr[AW-1:0]}];
            r_pyy <= r_mem_yy[{~i_addr[AW], i_addr[AW-1:0]}];
            r_pxy <= r_mem_xy[{~i_addr[AW], i_addr[AW-1:0]}];
        end
        if (i_cmd.wr) begin
            r_mem_xx[r_waddr] <= r_cxx;
            r_mem_yy[r_waddr] <= r_cyy;
            r_mem_xy[r_waddr] <= r_cxy;
        end
        if (i_cmd.step) begin
            case (i_stage)
                4'd0: begin
                    r_cxx <= 21'(r_gx * r_gx);
                    r_cyy <= 21'(r_gy * r_gy);
                    r_cxy <= 22'(r_gx * r_gy);
                end
                4'd1: begin
                    if (i_cmd.mirror) begin
                        r_oxx <= r_cxx; r_oyy <= r_cyy; r_oxy <= r_cxy;
                    end
                end
                4'd2: r_fxx <= 39'(i_wside * a_xx) + 39'(i_wctr * c_xx);
                4'd3: r_fyy <= 39'(i_wside * a_yy) + 39'(i_wctr * c_yy);
                4'd4: r_fxy <= 41'($signed({1'b0, i_wside}) * a_xy)
                             + 41'($signed({1'b0, i_wctr}) * c_xy);
                4'd5: begin
                    r_gxx <= 23'((r_fxx + 39'd32768) >> 16);
                    r_gyy <= 23'((r_fyy + 39'd32768) >> 16);
                    r_gxy <= 24'((r_fxy + 41'sd32768) >>> 16);
                end
                4'd6: r_det <= 48'(r_gxx * r_gyy);
                4'd7: r_det <= r_det - 48'(r_gxy * r_gxy);
                4'd8: r_tt  <= 48'(t_sum * t_sum);
                4'd9: r_at  <= 64'(r_tt[31:0] * i_alpha);
                4'd10: r_at <= r_at + {32'(r_tt[47:32] * i_alpha), 32'd0};
                4'd11: r_at <= (r_at + 64'd32768) >> 16;
                4'd12: begin
                    if (r_full > RESP_MAX_C) r_resp <= hcr_pkg::RESP_MAX;
                    else if (r_full < RESP_MIN_C) r_resp <= hcr_pkg::RESP_MIN;
                    else r_resp <= r_full[43:0];
                end
                default: ;
            endcase
        end
    end

    assign o_resp = r_resp;
endmodule

FILE: design/hcr_ctrl.sv
module hcr_ctrl #(
    parameter int MAX_WIDTH = hcr_pkg::MAX_WIDTH_DEF,
    parameter int AW = $clog2(MAX_WIDTH)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_last,
    input  logic [10:0]    i_width,
    input  logic [11:0]    i_height,
    output hcr_pkg::t_cmd  o_cmd,
    output logic [3:0]     o_stage,
    output logic [AW:0]    o_addr
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CALC = 4'b0010,
        S_OUT  = 4'b0100,
        S_WR   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [3:0] r_stage;
    logic [11:0] r_col, r_row;
    logic r_two, r_pass2, r_emit;

    logic [11:0] w_eff, h_eff, col0, row0;
    logic wrapc;

    always_comb begin
        w_eff = {1'b0, i_width};
        if (i_width < 11'd3) w_eff = 12'd3;
        if ({1'b0, w_eff} > 13'(MAX_WIDTH)) w_eff = 12'(MAX_WIDTH);
        h_eff = (i_height < 12'd3) ? 12'd3 : i_height;
        wrapc = r_col >= w_eff;
        col0 = wrapc ? 12'd0 : r_col;
        row0 = wrapc ? r_row + 12'd1 : r_row;
        if (row0 >= h_eff) row0 = 12'd0;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_last  = r_pass2 || !r_two;
    assign o_stage = r_stage;
    assign o_addr  = {row0[0], col0[AW-1:0]};

    always_comb begin
        o_cmd = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_valid;
        o_cmd.step   = (r_state == S_CALC);
        o_cmd.mirror = (r_row == 12'd1);
        o_cmd.pass2  = r_pass2;
        o_cmd.wr     = (r_state == S_WR);
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_CALC;
            S_CALC: if (r_stage == 4'd12) n_state = r_emit ? S_OUT : S_WR;
            S_OUT:  if (i_ready) n_state = (r_two && !r_pass2) ? S_CALC : S_WR;
            S_WR:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stage <= '0;
            r_col <= '0;
            r_row <= '0;
            r_two <= 1'b0;
            r_pass2 <= 1'b0;
            r_emit <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_stage <= '0;
                    r_col <= col0;
                    r_row <= row0;
                    r_emit <= row0 != 12'd0;
                    r_two <= row0 == h_eff - 12'd1;
                    r_pass2 <= 1'b0;
                end
                S_CALC: r_stage <= r_stage + 4'd1;
                S_OUT: if (i_ready) begin
                    r_pass2 <= 1'b1;
                    r_stage <= 4'd2;
                end
                S_WR: begin
                    if (r_col + 12'd1 >= w_eff) begin
                        r_col <= '0;
                        r_row <= (r_row + 12'd1 >= h_eff) ? 12'd0 : r_row + 12'd1;
                    end else begin
                        r_col <= r_col + 12'd1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

FILE: design/harris_corner_response_top.sv
// Harris corner response, vertical 3-tap smoothing, one-row result lag.
// Each item runs one load, 13 arithmetic steps on a shared multiplier path,
// one output and one buffer write; the first row sends no result and skips
// the output, and the last row adds a second result.
// Throughput is set by the sequenced shared datapath: one item at a time.
// Reset (i_rst_n low, synchronous): position to zero, registers to defaults.
module harris_corner_response_top #(
    parameter int MAX_WIDTH = hcr_pkg::MAX_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [10:0] i_grad_x,
    input  logic signed [10:0] i_grad_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [43:0] o_response,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int AW = $clog2(MAX_WIDTH);

    // configuration registers
    logic [10:0] r_width;
    logic [11:0] r_height;
    logic [15:0] r_alpha, r_wside, r_wctr;
    logic [2:0]  w_idx;

    assign pready = 1'b1;
    assign w_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= hcr_pkg::WIDTH_RST;
            r_height <= hcr_pkg::HEIGHT_RST;
            r_alpha  <= hcr_pkg::ALPHA_RST;
            r_wside  <= hcr_pkg::WSIDE_RST;
            r_wctr   <= hcr_pkg::WCTR_RST;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                hcr_pkg::REG_WIDTH:  r_width  <= pwdata[10:0];
                hcr_pkg::REG_HEIGHT: r_height <= pwdata[11:0];
                hcr_pkg::REG_ALPHA:  r_alpha  <= pwdata[15:0];
                hcr_pkg::REG_WSIDE:  r_wside  <= pwdata[15:0];
                hcr_pkg::REG_WCTR:   r_wctr   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            hcr_pkg::REG_WIDTH:  prdata = {21'd0, r_width};
            hcr_pkg::REG_HEIGHT: prdata = {20'd0, r_height};
            hcr_pkg::REG_ALPHA:  prdata = {16'd0, r_alpha};
            hcr_pkg::REG_WSIDE:  prdata = {16'd0, r_wside};
            hcr_pkg::REG_WCTR:   prdata = {16'd0, r_wctr};
            default:             prdata = '0;
        endcase
    end

    hcr_pkg::t_cmd w_cmd;
    logic [3:0]    w_stage;
    logic [AW:0]   w_addr;

    // sequencer: position tracking, stage count, handshakes
    hcr_ctrl #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_valid, .o_ready, .o_valid, .i_ready, .o_last,
        .i_width(r_width), .i_height(r_height),
        .o_cmd(w_cmd), .o_stage(w_stage), .o_addr(w_addr)
    );

    // line buffers and shared arithmetic
    hcr_datapath #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_dp (
        .i_clk,
        .i_cmd(w_cmd), .i_stage(w_stage), .i_addr(w_addr),
        .i_grad_x, .i_grad_y,
        .i_alpha(r_alpha), .i_wside(r_wside), .i_wctr(r_wctr),
        .o_resp(o_response)
    );

    // no new transfer accepted while a result is pending
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready during output");
    // result held until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_response))
        else $error("result dropped");
endmodule

FILE: bench/hcr_response_checker.sv
module hcr_response_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic signed [10:0] i_grad_x,
    input  logic signed [10:0] i_grad_y,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic signed [43:0] o_response,
    input  logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [43:0] resp;
        logic               last;
    } t_corner;

    t_corner     corner_q[$];
    longint      row_xx[2*hcr_pkg::MAX_WIDTH_DEF];
    longint      row_yy[2*hcr_pkg::MAX_WIDTH_DEF];
    longint      row_xy[2*hcr_pkg::MAX_WIDTH_DEF];
    int unsigned col_pos;
    int unsigned row_pos;
    logic [10:0] width_r;
    logic [11:0] height_r;
    logic [15:0] alpha_r;
    logic [15:0] wside_r;
    logic [15:0] wctr_r;

    task automatic report(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    // 3-tap vertical smoothing, round half up (floor of s/2^16 + 1/2)
    function automatic longint smooth3(longint above, longint ctr, longint below);
        longint s;
        s = longint'(wside_r) * (above + below) + longint'(wctr_r) * ctr;
        return (s + 32768) >>> 16;
    endfunction

    function automatic logic signed [43:0] harris(longint xa, longint xc, longint xb,
                                                  longint ya, longint yc, longint yb,
                                                  longint pa, longint pc, longint pb);
        longint fxx, fyy, fxy, det, tr, a, r;
        fxx = smooth3(xa, xc, xb);
        fyy = smooth3(ya, yc, yb);
        fxy = smooth3(pa, pc, pb);
        det = fxx * fyy - fxy * fxy;
        tr  = fxx + fyy;
        a   = (longint'(alpha_r) * tr * tr + 32768) >>> 16;
        r   = det - a;
        if (r > longint'(hcr_pkg::RESP_MAX)) r = longint'(hcr_pkg::RESP_MAX);
        if (r < longint'(hcr_pkg::RESP_MIN)) r = longint'(hcr_pkg::RESP_MIN);
        return r[43:0];
    endfunction

    always @(posedge i_clk) begin
        int unsigned w, h, cur, oth;
        longint cxx, cyy, cxy, oxx, oyy, oxy, pxx, pyy, pxy;
        t_corner exp_c;
        if (!i_rst_n) begin
            corner_q.delete();
            col_pos  = 0;
            row_pos  = 0;
            width_r  = hcr_pkg::WIDTH_RST;
            height_r = hcr_pkg::HEIGHT_RST;
            alpha_r  = hcr_pkg::ALPHA_RST;
            wside_r  = hcr_pkg::WSIDE_RST;
            wctr_r   = hcr_pkg::WCTR_RST;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    hcr_pkg::REG_WIDTH:  width_r  = pwdata[10:0];
                    hcr_pkg::REG_HEIGHT: height_r = pwdata[11:0];
                    hcr_pkg::REG_ALPHA:  alpha_r  = pwdata[15:0];
                    hcr_pkg::REG_WSIDE:  wside_r  = pwdata[15:0];
                    hcr_pkg::REG_WCTR:   wctr_r   = pwdata[15:0];
                    default: ;
                endcase
            end

            if (i_valid && o_ready) begin
                w = (width_r < 3) ? 3
                  : (width_r > hcr_pkg::MAX_WIDTH_DEF) ? hcr_pkg::MAX_WIDTH_DEF : width_r;
                h = (height_r < 3) ? 3 : height_r;
                if (col_pos >= w) begin
                    col_pos = 0;
                    row_pos++;
                end
                if (row_pos >= h) row_pos = 0;
                cxx = longint'(i_grad_x) * longint'(i_grad_x);
                cyy = longint'(i_grad_y) * longint'(i_grad_y);
                cxy = longint'(i_grad_x) * longint'(i_grad_y);
                cur = (row_pos % 2) * hcr_pkg::MAX_WIDTH_DEF + col_pos;
                oth = ((row_pos % 2) ^ 1) * hcr_pkg::MAX_WIDTH_DEF + col_pos;
                oxx = row_xx[cur]; oyy = row_yy[cur]; oxy = row_xy[cur];
                pxx = row_xx[oth]; pyy = row_yy[oth]; pxy = row_xy[oth];
                if (row_pos >= 1) begin
                    // top row mirrored: row 1 stands in for the row above row 0
                    if (row_pos == 1) begin
                        oxx = cxx; oyy = cyy; oxy = cxy;
                    end
                    exp_c.resp = harris(oxx, pxx, cxx, oyy, pyy, cyy, oxy, pxy, cxy);
                    exp_c.last = (row_pos != h - 1);
                    corner_q = {corner_q, exp_c};
                    // bottom row: extra result, row above mirrored below
                    if (row_pos == h - 1) begin
                        exp_c.resp = harris(pxx, cxx, pxx, pyy, cyy, pyy, pxy, cxy, pxy);
                        exp_c.last = 1'b1;
                        corner_q = {corner_q, exp_c};
                    end
                end
                row_xx[cur] = cxx;
                row_yy[cur] = cyy;
                row_xy[cur] = cxy;
                col_pos++;
                if (col_pos >= w) begin
                    col_pos = 0;
                    row_pos++;
                    if (row_pos >= h) row_pos = 0;
                end
            end

            if (o_valid && i_ready) begin
                if (corner_q.size() == 0) begin
                    report($sformatf("unexpected result %0d", o_response));
                end else begin
                    exp_c = corner_q.pop_front();
                    if (o_response !== exp_c.resp)
                        report($sformatf("response got %0d exp %0d", o_response, exp_c.resp));
                    if (o_last !== exp_c.last)
                        report($sformatf("last got %b exp %b", o_last, exp_c.last));
                end
            end
        end
        o_pending <= corner_q.size();
    end

endmodule

FILE: bench/harris_corner_response_top_test.sv
module harris_corner_response_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [10:0] i_grad_x;
    logic signed [10:0] i_grad_y;
    logic               o_valid;
    logic               i_ready;
    logic signed [43:0] o_response;
    logic               o_last;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    int                 rand_items;

    harris_corner_response_top i_dut (.*);

    hcr_response_checker i_chk (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_grad_x, .i_grad_y,
        .o_valid, .i_ready, .o_response, .o_last,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // idle lengths: mostly none or short, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // gradient: mostly in the Sobel range, some edges, some raw 11-bit codes
    function automatic logic [10:0] rand_grad();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 11'($urandom_range(0, 2047));
        if (r < 20) return $urandom_range(0, 1) ? 11'sd1020 : -11'sd1020;
        return 11'($urandom_range(0, 2040) - 1020);
    endfunction

    // 16-bit weight / alpha with extremes weighted in
    function automatic logic [15:0] rand_q16(input logic [15:0] dflt);
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return dflt;
        if (r == 3) return 16'd0;
        if (r == 4) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // one APB write: setup cycle, then access; pready is tied high in the DUT
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
    endtask

    // drain the block, then reprogram every register
    task automatic set_frame(input logic [10:0] w, input logic [11:0] h,
                             input logic [15:0] a, input logic [15:0] ws,
                             input logic [15:0] wc);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);   // last item may still be writing its buffer
        reg_write(hcr_pkg::REG_WIDTH, 32'(w));
        reg_write(hcr_pkg::REG_HEIGHT, 32'(h));
        reg_write(hcr_pkg::REG_ALPHA, 32'(a));
        reg_write(hcr_pkg::REG_WSIDE, 32'(ws));
        reg_write(hcr_pkg::REG_WCTR, 32'(wc));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one input transfer; valid stays high into the next call when no gap
    task automatic send_pixel(input logic [10:0] gx, input logic [10:0] gy,
                              input bit no_gaps);
        int g;
        g = no_gaps ? 0 : gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_grad_x <= gx;
        i_grad_y <= gy;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_frame(input int w, input int h);
        bit no_gaps;
        no_gaps = ($urandom_range(0, 3) == 0);
        repeat (w * h) send_pixel(rand_grad(), rand_grad(), no_gaps);
    endtask

    // output side: random stalls, with stretches of steady ready
    initial begin
        int g;
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            g = gap_len();
            if (g > 0) begin
                i_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(0, 9) == 0 ? 300 : $urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    initial begin
        logic [10:0] dir_gx [12];
        logic [10:0] dir_gy [12];
        int w, h;
        dir_gx = '{11'h400, 11'sd1023, -11'sd1020, 11'sd1020, 11'sd0, -11'sd1,
                   11'sd1020, 11'sd0, -11'sd1020, 11'sd512, 11'sd1023, 11'h400};
        dir_gy = '{11'sd1023, 11'h400, 11'sd1020, 11'sd1020, 11'sd0, 11'sd1,
                   11'sd0, 11'sd1020, -11'sd1020, -11'sd512, 11'sd1023, 11'h400};
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_grad_x <= '0;
        i_grad_y <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        rand_items = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 3x4 frame with field extremes (silent top row, mirrored
        // row 1, double results on the bottom row), then again at max weights
        set_frame(11'd3, 12'd4, hcr_pkg::ALPHA_RST, hcr_pkg::WSIDE_RST, hcr_pkg::WCTR_RST);
        for (int k = 0; k < 12; k++) send_pixel(dir_gx[k], dir_gy[k], 1'b0);
        set_frame(11'd3, 12'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int k = 0; k < 12; k++) send_pixel(dir_gx[k], dir_gy[k], 1'b1);

        // random small frames, settings drawn per frame
        while (rand_items < 1100) begin
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            set_frame(11'(w), 12'(h), rand_q16(hcr_pkg::ALPHA_RST),
                      rand_q16(hcr_pkg::WSIDE_RST), rand_q16(hcr_pkg::WCTR_RST));
            send_frame(w, h);
            rand_items += w * h;
        end

        // size clamping: zero and below-minimum settings
        set_frame(11'd0, 12'd0, rand_q16(hcr_pkg::ALPHA_RST),
                  rand_q16(hcr_pkg::WSIDE_RST), 16'd0);
        send_frame(3, 3);
        set_frame(11'd2, 12'd2, hcr_pkg::ALPHA_RST, 16'd0, hcr_pkg::WCTR_RST);
        send_frame(3, 3);

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog: several times the slowest legal run
    initial begin
        #(20_000_000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
